// ----- rtl/int64_to_radix_text_defines.svh -----
// assertion macros shared by the int64_to_radix_text rtl
`ifndef INT64_TO_RADIX_TEXT_DEFINES_SVH
`define INT64_TO_RADIX_TEXT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define I2RT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2rt assertion failed");

// next-cycle implication, disabled while reset is asserted
`define I2RT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2rt assertion failed");

`endif

// ----- rtl/i2rt_pkg.sv -----
// types, constants and helpers shared by the int64_to_radix_text rtl
package i2rt_pkg;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;

    // carry handed from one digit cell to the next, with its step enable
    typedef struct packed {
        logic en;
        logic carry;
    } t_link;

    // row-wide controls for the digit cells
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(RADIX_DEC)) begin
            return ASCII_ZERO + dw;
        end
        return ASCII_A + dw - {{(CHAR_W-RADIX_W){1'b0}}, RADIX_DEC};
    endfunction

endpackage

// ----- rtl/i2rt_cell.sv -----
// one digit cell: doubles its digit, adds the incoming carry, reduces by the radix, or clears or loads a digit
module i2rt_cell
    import i2rt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_cell_ctl          i_ctl,
    input  t_link              i_link,
    input  logic [DIGIT_W-1:0] i_shift_digit,
    output t_link              o_link,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit, n_digit;
    t_link              r_link, n_link;
    logic [DIGIT_W:0]   w_sum;
    logic [DIGIT_W:0]   w_rad;
    logic               w_over;

    assign w_sum  = {r_digit, i_link.carry};
    assign w_rad  = {1'b0, i_radix};
    assign w_over = (w_sum >= w_rad);

    always_comb begin
        n_digit = r_digit;
        n_link  = '0;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = i_shift_digit;
        end else if (i_link.en) begin
            n_digit      = w_over ? DIGIT_W'(w_sum - w_rad) : DIGIT_W'(w_sum);
            n_link.en    = 1'b1;
            n_link.carry = w_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_link  = r_link;
    assign o_digit = r_digit;

endmodule

// ----- rtl/int64_to_radix_text.sv -----
// top level: signed integer to ascii text in radix 2..36 on a row of digit cells
//
// input channel: i_valid / o_stall carry i_value and i_radix; a transfer takes
// place on a clock edge with i_valid high and o_stall low. o_stall is high
// while an item is being converted or its text is still being produced.
// output channel: o_valid / i_stall carry o_character and o_last, one transfer
// per character, most significant digit first; o_last marks the final one.
// radix 10 with a negative value prints '-' and the magnitude; other radixes
// read the low VALUE_BITS bits as an unsigned pattern; radix is clamped to 2..36.
// conversion: the value bits enter cell 0 msb first, one per cycle, and each
// cell's carry reaches its upper neighbor in the cycle after. the row then
// shifts up one cell per cycle, skipping leading zeros and emitting digits,
// while the top digit is a skipped zero or the output register is free;
// a negative decimal value emits its sign first. a stall of the receiver
// holds the row only when a character is ready while the output register
// is still held.
// the last character sits in the output register while the next item is taken.
// reset (synchronous, active low) empties the output register and returns
// the controller to idle; digit cells are cleared on each accepted item.
module int64_to_radix_text
    import i2rt_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               o_stall,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_character,
    output logic               o_last,
    input  logic               i_stall
);

`include "int64_to_radix_text_defines.svh"

    localparam int CNT_W = $clog2(2 * VALUE_BITS);
    localparam int REM_W = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // control registers
    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic                  r_sign, n_sign;
    logic                  r_started, n_started;
    logic                  r_out_valid, n_out_valid;

    // payload registers
    logic [VALUE_BITS-1:0] r_feed, n_feed;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    // input side decode
    logic                  w_in_xfer;
    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_neg;
    logic [RADIX_W-1:0]    w_radix_sat;
    logic                  w_is_neg;

    // cell row
    t_cell_ctl             w_ctl;
    t_link                 w_link  [VALUE_BITS+1];
    logic [DIGIT_W-1:0]    w_digit [VALUE_BITS];
    logic [DIGIT_W-1:0]    w_top;

    // emission decode
    logic                  w_out_free;
    logic                  w_skip;
    logic                  w_feed_en;

    assign w_in_xfer = i_valid && !o_stall;
    assign w_val     = i_value[VALUE_BITS-1:0];
    assign w_neg     = ~w_val + VALUE_BITS'(1);

    always_comb begin
        w_radix_sat = i_radix;
        if (i_radix < RADIX_MIN) begin
            w_radix_sat = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            w_radix_sat = RADIX_MAX;
        end
    end

    assign w_is_neg   = (w_radix_sat == RADIX_DEC) && w_val[VALUE_BITS-1];
    assign w_feed_en  = (r_state == ST_CONV) && (r_cnt < CNT_W'(VALUE_BITS));
    assign w_top      = w_digit[VALUE_BITS-1];
    assign w_out_free = !r_out_valid || !i_stall;
    // leading zeros are dropped, but the units digit is always printed
    assign w_skip     = !r_started && (w_top == '0) && (r_rem != REM_W'(1));

    // cell 0 takes the value msb first
    assign w_link[0].en    = w_feed_en;
    assign w_link[0].carry = r_feed[VALUE_BITS-1];

    always_comb begin
        w_ctl.clear = w_in_xfer;
        w_ctl.shift = (r_state == ST_EMIT) && !r_sign && (w_skip || w_out_free);
    end

    for (genvar g = 0; g < VALUE_BITS; g++) begin : g_cell
        logic [DIGIT_W-1:0] w_below;
        if (g == 0) begin : g_first
            assign w_below = '0;
        end else begin : g_rest
            assign w_below = w_digit[g-1];
        end
        i2rt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_radix       (r_radix),
            .i_ctl         (w_ctl),
            .i_link        (w_link[g]),
            .i_shift_digit (w_below),
            .o_link        (w_link[g+1]),
            .o_digit       (w_digit[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_sign      = r_sign;
        n_started   = r_started;
        n_feed      = r_feed;
        n_radix     = r_radix;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid;

        // the receiver takes the held character
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state   = ST_CONV;
                    n_cnt     = '0;
                    n_rem     = REM_W'(VALUE_BITS);
                    n_sign    = w_is_neg;
                    n_started = 1'b0;
                    n_feed    = w_is_neg ? w_neg : w_val;
                    n_radix   = w_radix_sat;
                end
            end
            ST_CONV: begin
                n_feed = {r_feed[VALUE_BITS-2:0], 1'b0};
                n_cnt  = r_cnt + CNT_W'(1);
                // last step reaches the top cell on this cycle
                if (r_cnt == CNT_W'(2 * VALUE_BITS - 2)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_sign) begin
                    if (w_out_free) begin
                        n_char      = ASCII_MINUS;
                        n_last      = 1'b0;
                        n_out_valid = 1'b1;
                        n_sign      = 1'b0;
                    end
                end else if (w_skip) begin
                    n_rem = r_rem - REM_W'(1);
                end else if (w_out_free) begin
                    n_char      = digit_char(w_top);
                    n_last      = (r_rem == REM_W'(1));
                    n_out_valid = 1'b1;
                    n_started   = 1'b1;
                    n_rem       = r_rem - REM_W'(1);
                    if (r_rem == REM_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_sign      <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_sign      <= n_sign;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_feed  <= n_feed;
        r_radix <= n_radix;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // the row is as long as radix 2 needs, so the top cell never carries out
    `I2RT_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_link[VALUE_BITS].en,
        !w_link[VALUE_BITS].carry)
    // every digit leaving the row is a valid digit of the radix
    `I2RT_ASSERT_IMPL(a_digit_range, i_clk, i_rst_n, r_state == ST_EMIT,
        w_top < r_radix)
    // a sign is only pending for a decimal conversion
    `I2RT_ASSERT_IMPL(a_sign_dec, i_clk, i_rst_n, r_sign, r_radix == RADIX_DEC)
    // a final character always leaves the controller idle
    `I2RT_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        r_state == ST_EMIT && !r_sign && !w_skip && w_out_free && r_rem == REM_W'(1),
        r_state == ST_IDLE && r_out_valid && r_last)

endmodule
